FILE: rtl/psbd_pkg.sv
package psbd_pkg;

    // Filter geometry and bit timing
    localparam int SHAPING_TAPS     = 35;
    localparam int EQUALIZER_TAPS   = 45;
    localparam int SAMPLES_PER_BIT  = 12;
    localparam int BITS_PER_WORD    = 5;
    localparam int ALIGN            = (SHAPING_TAPS - 1) / 2;
    localparam int LAG              = ALIGN + EQUALIZER_TAPS - 1;
    localparam int CARRIER_PERIOD   = 6;

    // Datapath widths
    localparam int SAMPLE_W   = 8;
    localparam int MIX_W      = 10;
    localparam int SHP_W      = 29;
    localparam int COEF_W     = 17;
    localparam int PROD_W     = SHP_W + COEF_W;
    localparam int ACC_W      = 48;
    localparam int IDX_W      = 11;
    localparam int PHASE_W    = 3;
    localparam int WPF_W      = 5;
    localparam int TDATA_W    = 8;
    localparam int TAP_IDX_W  = $clog2(EQUALIZER_TAPS);

    localparam logic [IDX_W-1:0] SAMPLE_INDEX_MAX = {IDX_W{1'b1}};

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_WORDS_PER_FRAME = 1'b0;
    localparam logic [WPF_W-1:0] WPF_RESET = 5'd22;

    // Control of one tap ring
    typedef struct packed {
        logic clear;   // zero every cell
        logic shift;   // every cell takes its neighbor's value
        logic load;    // head takes a new value instead of the tail
    } chain_ctl_t;

    // Root-raised-cosine matched filter
    localparam logic signed [COEF_W-1:0] SHAPING_COEF [SHAPING_TAPS] = '{
        -17'sd183,   17'sd1141,  17'sd2387,  17'sd3088,  17'sd2855,  17'sd1530,
        -17'sd709,  -17'sd3331, -17'sd5541, -17'sd6451, -17'sd5320, -17'sd1772,
         17'sd4053,  17'sd11463, 17'sd19322, 17'sd26280, 17'sd31063, 17'sd32767,
         17'sd31063, 17'sd26280, 17'sd19322, 17'sd11463, 17'sd4053, -17'sd1772,
        -17'sd5320, -17'sd6451, -17'sd5541, -17'sd3331, -17'sd709,   17'sd1530,
         17'sd2855,  17'sd3088,  17'sd2387,  17'sd1141, -17'sd183
    };

    // Equalizer
    localparam logic signed [COEF_W-1:0] EQUALIZER_COEF [EQUALIZER_TAPS] = '{
        -17'sd739,  -17'sd1411, -17'sd1968, -17'sd2152, -17'sd1764, -17'sd768,
         17'sd650,   17'sd2089,  17'sd386,  -17'sd2136, -17'sd1426, -17'sd436,
         17'sd684,   17'sd1762,  17'sd2636,  17'sd3184,  17'sd3344,  17'sd3125,
         17'sd2592,  17'sd1850,  17'sd1028,  17'sd263,  -17'sd324,  -17'sd652,
        -17'sd694,  -17'sd481,  -17'sd89,    17'sd374,   17'sd788,   17'sd1047,
         17'sd1074,  17'sd841,   17'sd367,  -17'sd282,  -17'sd1013, -17'sd1714,
        -17'sd136,   17'sd767,   17'sd954,   17'sd622,   17'sd90,   -17'sd313,
        -17'sd363,  -17'sd2,    -17'sd1476
    };

    // Sample times doubled carrier cosine: 2, 1, -1, -2, -1, 1
    function automatic logic signed [MIX_W-1:0] carrier_mix(
        input logic signed [SAMPLE_W-1:0] x,
        input logic [PHASE_W-1:0]         ph
    );
        logic signed [MIX_W-1:0] xe;
        xe = MIX_W'(x);
        case (ph)
            3'd0:    carrier_mix = xe <<< 1;
            3'd1:    carrier_mix = xe;
            3'd2:    carrier_mix = -xe;
            3'd3:    carrier_mix = -(xe <<< 1);
            3'd4:    carrier_mix = -xe;
            3'd5:    carrier_mix = xe;
            default: carrier_mix = '0;
        endcase
    endfunction

endpackage

FILE: rtl/psbd_tap_cell.sv
module psbd_tap_cell #(
    parameter int WIDTH = psbd_pkg::SHP_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  psbd_pkg::chain_ctl_t     ctl,
    input  logic signed [WIDTH-1:0]  d_in,
    output logic signed [WIDTH-1:0]  d_out
);

    logic signed [WIDTH-1:0] data_reg;
    logic signed [WIDTH-1:0] data_next;

    // clear wins over shift; otherwise hold
    always_comb begin
        if (ctl.clear) begin
            data_next = '0;
        end else if (ctl.shift) begin
            data_next = d_in;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

FILE: rtl/psbd_tap_chain.sv
module psbd_tap_chain #(
    parameter int WIDTH = psbd_pkg::SHP_W,
    parameter int TAPS  = psbd_pkg::EQUALIZER_TAPS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  psbd_pkg::chain_ctl_t     ctl,
    input  logic signed [WIDTH-1:0]  din,
    output logic signed [WIDTH-1:0]  tail
);

    // link[k] feeds cell k, cell k drives link[k+1]
    logic signed [WIDTH-1:0] link [TAPS+1];

    // head takes the new value on load, else the ring wraps the tail around
    assign link[0] = ctl.load ? din : link[TAPS];
    assign tail    = link[TAPS];

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        psbd_tap_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .d_in    (link[k]),
            .d_out   (link[k+1])
        );
    end

endmodule

FILE: rtl/pulse_shaped_bpsk_demodulator.sv
// BPSK demodulator for framed 8-bit samples. Each sample is mixed down by a
// six-phase carrier, filtered by a 35-tap root-raised-cosine FIR, delayed by
// 17 samples and filtered again by a 45-tap equalizer; every 12 samples the
// equalizer outputs at offsets 0 and 6 decide one bit, and five bits form one
// output word (earliest bit in bit 4). A sample with s_tuser set starts a new
// frame: filters, carrier phase and counters restart. At most words_per_frame
// words leave per frame (register at APB address 0, reset 22, 0 = none); the
// last one carries m_tlast. Both delay lines are rings of tap cells that
// rotate past one shared multiply-accumulate, one tap per cycle. During the
// first 17 samples of a frame a sample is only loaded into the mixer ring;
// after that the matched filter runs for each sample, and at the two
// decision points of a bit period (offsets 0 and 6) the equalizer runs as
// well, followed by any wait for a free output register.
// The block takes one sample at a time; a finished word may wait in the
// output register while the next samples are taken.
module pulse_shaped_bpsk_demodulator #(
    parameter int SAMPLES_PER_BIT = psbd_pkg::SAMPLES_PER_BIT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [psbd_pkg::TDATA_W-1:0]        s_tdata,   // [7:0] sample_in
    input  logic                                s_tuser,   // [0] frame_start
    // word output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [psbd_pkg::TDATA_W-1:0]        m_tdata,   // [4:0] packed_word
    output logic                                m_tlast,   // last_word
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psbd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [psbd_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [psbd_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int HALF_BIT  = SAMPLES_PER_BIT / 2;
    localparam int BC_W      = (SAMPLES_PER_BIT > 2) ? $clog2(SAMPLES_PER_BIT) : 1;
    localparam int BPW       = psbd_pkg::BITS_PER_WORD;
    localparam int BIW_W     = (BPW > 2) ? $clog2(BPW) : 1;
    localparam int IDX_W     = psbd_pkg::IDX_W;
    localparam int ACC_W     = psbd_pkg::ACC_W;
    localparam int SUM_W     = ACC_W + 1;
    localparam int PROD_W    = psbd_pkg::PROD_W;
    localparam int SHP_W     = psbd_pkg::SHP_W;
    localparam int MIX_W     = psbd_pkg::MIX_W;
    localparam int COEF_W    = psbd_pkg::COEF_W;
    localparam int TAP_IDX_W = psbd_pkg::TAP_IDX_W;
    localparam int PHASE_W   = psbd_pkg::PHASE_W;
    localparam int WPF_W     = psbd_pkg::WPF_W;

    localparam logic [IDX_W-1:0]     ALIGN_IDX  = IDX_W'(psbd_pkg::ALIGN);
    localparam logic [IDX_W-1:0]     LAG_IDX    = IDX_W'(psbd_pkg::LAG);
    localparam logic [BC_W-1:0]      BC_LAST    = BC_W'(SAMPLES_PER_BIT - 1);
    localparam logic [BC_W-1:0]      BC_HALF    = BC_W'(HALF_BIT);
    localparam logic [BIW_W-1:0]     BIW_LAST   = BIW_W'(BPW - 1);
    localparam logic [PHASE_W-1:0]   PH_LAST    = PHASE_W'(psbd_pkg::CARRIER_PERIOD - 1);
    localparam logic [TAP_IDX_W-1:0] SHP_TAP0   = TAP_IDX_W'(psbd_pkg::SHAPING_TAPS - 1);
    localparam logic [TAP_IDX_W-1:0] EQ_TAP0    = TAP_IDX_W'(psbd_pkg::EQUALIZER_TAPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_MIX,
        ST_MAC_MIX,
        ST_DRAIN_MIX,
        ST_LOAD_SHP,
        ST_MAC_EQ,
        ST_DRAIN_EQ,
        ST_DECIDE
    } state_t;

    state_t                         state_reg;
    logic [WPF_W-1:0]               wpf_reg;
    logic [IDX_W-1:0]               sample_index_reg;
    logic [PHASE_W-1:0]             carrier_phase_reg;
    logic [BC_W-1:0]                bit_cnt_reg;
    logic [IDX_W-1:0]               n_reg;
    logic [BC_W-1:0]                q_reg;
    logic signed [MIX_W-1:0]        mixed_reg;
    logic [TAP_IDX_W-1:0]           tap_cnt_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           prod_vld_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        first_half_sum_reg;
    logic [BPW-1:0]                 bit_shift_reg;
    logic [BIW_W-1:0]               bits_in_word_reg;
    logic [WPF_W-1:0]               words_done_reg;
    logic                           m_tvalid_reg;
    logic [BPW-1:0]                 word_reg;
    logic                           last_reg;

    logic                           in_beat;
    logic                           cfg_wr;
    logic [IDX_W-1:0]               idx_cur;
    logic [PHASE_W-1:0]             ph_cur;
    logic [BC_W-1:0]                bc_cur;
    psbd_pkg::chain_ctl_t           mix_ctl;
    psbd_pkg::chain_ctl_t           shp_ctl;
    logic signed [MIX_W-1:0]        mix_tail;
    logic signed [SHP_W-1:0]        shp_tail;
    logic signed [SHP_W-1:0]        data_sel;
    logic signed [COEF_W-1:0]       coef_sel;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [SUM_W-1:0]        dec_sum;
    logic                           dec_bit;
    logic [BPW-1:0]                 bit_shift_next;
    logic                           out_free;
    logic                           word_issue;
    logic                           run_eq;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // a finished word enters the output register this cycle
    assign word_issue = (state_reg == ST_DECIDE) && (q_reg != '0)
                        && (bits_in_word_reg == BIW_LAST) && out_free;

    // APB: single register, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[psbd_pkg::CFG_ADDR_W-1] == psbd_pkg::REG_WORDS_PER_FRAME);
    assign prdata = (paddr[psbd_pkg::CFG_ADDR_W-1] == psbd_pkg::REG_WORDS_PER_FRAME)
                    ? psbd_pkg::CFG_DATA_W'(wpf_reg) : '0;

    // frame start restarts index, carrier and bit timing for this sample
    assign idx_cur = s_tuser ? '0 : sample_index_reg;
    assign ph_cur  = s_tuser ? '0 : carrier_phase_reg;
    assign bc_cur  = s_tuser ? '0 : bit_cnt_reg;

    // tap ring controls
    always_comb begin
        mix_ctl.clear = in_beat && s_tuser;
        mix_ctl.shift = (state_reg == ST_LOAD_MIX) || (state_reg == ST_MAC_MIX);
        mix_ctl.load  = (state_reg == ST_LOAD_MIX);
        shp_ctl.clear = in_beat && s_tuser;
        shp_ctl.shift = (state_reg == ST_LOAD_SHP) || (state_reg == ST_MAC_EQ);
        shp_ctl.load  = (state_reg == ST_LOAD_SHP);
    end

    psbd_tap_chain #(
        .WIDTH (MIX_W),
        .TAPS  (psbd_pkg::SHAPING_TAPS)
    ) u_mix_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mix_ctl),
        .din     (mixed_reg),
        .tail    (mix_tail)
    );

    psbd_tap_chain #(
        .WIDTH (SHP_W),
        .TAPS  (psbd_pkg::EQUALIZER_TAPS)
    ) u_shp_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (shp_ctl),
        .din     (acc_reg[SHP_W-1:0]),
        .tail    (shp_tail)
    );

    // shared multiplier: tail of the rotating ring times its coefficient
    always_comb begin
        if (state_reg == ST_MAC_MIX) begin
            data_sel = SHP_W'(mix_tail);
            coef_sel = psbd_pkg::SHAPING_COEF[tap_cnt_reg];
        end else begin
            data_sel = shp_tail;
            coef_sel = psbd_pkg::EQUALIZER_COEF[tap_cnt_reg];
        end
        prod_next = PROD_W'(data_sel) * PROD_W'(coef_sel);
    end

    // bit decision: offset 0 plus offset half-bit, strictly positive
    assign dec_sum        = SUM_W'(first_half_sum_reg) + SUM_W'(acc_reg);
    assign dec_bit        = !dec_sum[SUM_W-1] && (dec_sum != '0);
    assign bit_shift_next = {bit_shift_reg[BPW-2:0], dec_bit};

    // equalizer only at the two decision offsets, once its ring is full, inside the frame's word budget
    assign run_eq = (n_reg >= LAG_IDX) && (n_reg != psbd_pkg::SAMPLE_INDEX_MAX)
                    && (words_done_reg < wpf_reg)
                    && ((q_reg == '0) || (q_reg == BC_HALF));

    // sequencer and all registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            wpf_reg            <= psbd_pkg::WPF_RESET;
            sample_index_reg   <= '0;
            carrier_phase_reg  <= '0;
            bit_cnt_reg        <= '0;
            n_reg              <= '0;
            q_reg              <= '0;
            mixed_reg          <= '0;
            tap_cnt_reg        <= '0;
            prod_reg           <= '0;
            prod_vld_reg       <= 1'b0;
            acc_reg            <= '0;
            first_half_sum_reg <= '0;
            bit_shift_reg      <= '0;
            bits_in_word_reg   <= '0;
            words_done_reg     <= '0;
            m_tvalid_reg       <= 1'b0;
            word_reg           <= '0;
            last_reg           <= 1'b0;
        end else begin
            if (cfg_wr) begin
                wpf_reg <= pwdata[WPF_W-1:0];
            end
            if (m_tvalid_reg && m_tready && !word_issue) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        n_reg     <= idx_cur;
                        mixed_reg <= psbd_pkg::carrier_mix(
                                         signed'(s_tdata[psbd_pkg::SAMPLE_W-1:0]), ph_cur);
                        sample_index_reg  <= (idx_cur == psbd_pkg::SAMPLE_INDEX_MAX)
                                             ? idx_cur : idx_cur + IDX_W'(1);
                        carrier_phase_reg <= (ph_cur == PH_LAST)
                                             ? '0 : ph_cur + PHASE_W'(1);
                        // bit-period offset counts samples from the first decision slot
                        q_reg <= bc_cur;
                        if (idx_cur >= LAG_IDX) begin
                            bit_cnt_reg <= (bc_cur == BC_LAST) ? '0 : bc_cur + BC_W'(1);
                        end else begin
                            bit_cnt_reg <= bc_cur;
                        end
                        if (s_tuser) begin
                            first_half_sum_reg <= '0;
                            bit_shift_reg      <= '0;
                            bits_in_word_reg   <= '0;
                            words_done_reg     <= '0;
                        end
                        state_reg <= ST_LOAD_MIX;
                    end
                end

                ST_LOAD_MIX: begin
                    tap_cnt_reg  <= SHP_TAP0;
                    acc_reg      <= '0;
                    prod_vld_reg <= 1'b0;
                    state_reg    <= (n_reg < ALIGN_IDX) ? ST_IDLE : ST_MAC_MIX;
                end

                ST_MAC_MIX: begin
                    prod_reg     <= prod_next;
                    prod_vld_reg <= 1'b1;
                    if (prod_vld_reg) begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                    if (tap_cnt_reg == '0) begin
                        state_reg <= ST_DRAIN_MIX;
                    end else begin
                        tap_cnt_reg <= tap_cnt_reg - TAP_IDX_W'(1);
                    end
                end

                ST_DRAIN_MIX: begin
                    acc_reg      <= acc_reg + ACC_W'(prod_reg);
                    prod_vld_reg <= 1'b0;
                    state_reg    <= ST_LOAD_SHP;
                end

                ST_LOAD_SHP: begin
                    tap_cnt_reg <= EQ_TAP0;
                    acc_reg     <= '0;
                    state_reg   <= run_eq ? ST_MAC_EQ : ST_IDLE;
                end

                ST_MAC_EQ: begin
                    prod_reg     <= prod_next;
                    prod_vld_reg <= 1'b1;
                    if (prod_vld_reg) begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                    if (tap_cnt_reg == '0) begin
                        state_reg <= ST_DRAIN_EQ;
                    end else begin
                        tap_cnt_reg <= tap_cnt_reg - TAP_IDX_W'(1);
                    end
                end

                ST_DRAIN_EQ: begin
                    acc_reg      <= acc_reg + ACC_W'(prod_reg);
                    prod_vld_reg <= 1'b0;
                    state_reg    <= ST_DECIDE;
                end

                ST_DECIDE: begin
                    if (q_reg == '0) begin
                        first_half_sum_reg <= acc_reg;
                        state_reg          <= ST_IDLE;
                    end else if (bits_in_word_reg != BIW_LAST) begin
                        bit_shift_reg    <= bit_shift_next;
                        bits_in_word_reg <= bits_in_word_reg + BIW_W'(1);
                        state_reg        <= ST_IDLE;
                    end else if (out_free) begin
                        // word complete: hand it to the output register
                        word_reg         <= bit_shift_next;
                        last_reg         <= (words_done_reg + WPF_W'(1)) == wpf_reg;
                        m_tvalid_reg     <= 1'b1;
                        words_done_reg   <= words_done_reg + WPF_W'(1);
                        bit_shift_reg    <= '0;
                        bits_in_word_reg <= '0;
                        state_reg        <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = psbd_pkg::TDATA_W'(word_reg);
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_bits_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_in_word_reg < BIW_W'(BPW))
        else $error("bit count within word out of range");

    a_bit_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_cnt_reg <= BC_LAST)
        else $error("bit-period offset out of range");

    a_word_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("word issued outside decision step");

    a_mac_empty_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !prod_vld_reg)
        else $error("sample taken with a product still in flight");
`endif

endmodule
